/* design/slfe_pkg.sv */
// Shared types and constants for the sync-length frame extractor.
// Used by slfe_parser, slfe_outq and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slfe_pkg;

    localparam logic [7:0]  SYNC_BYTE   = 8'h02;
    localparam logic [2:0]  SYNC_LEN    = 3'd4;
    localparam logic [2:0]  LEN_BYTES   = 3'd4;
    localparam logic [32:0] FRAME_EXTRA = 33'd9;
    localparam logic [3:0]  HEADER_LEN  = 4'd8;
    localparam int          LIMIT_W     = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd4096;

    // Output queue geometry.
    localparam int          Q_AW    = 4;
    localparam int          Q_DEPTH = 1 << Q_AW;
    localparam logic [Q_AW:0] Q_ROOM_MAX = (Q_AW+1)'(Q_DEPTH) - (Q_AW+1)'(HEADER_LEN);

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_PASS = 3'b100
    } t_phase;

    // One result word.
    typedef struct packed {
        logic       link_lost;
        logic       frame_end;
        logic       frame_start;
        logic [7:0] data;
    } t_res;

    // Words pushed into the output queue for one accepted input word.
    typedef struct packed {
        logic [3:0]     cnt;
        t_res [7:0]     ent;
    } t_push;

endpackage

`default_nettype wire

/* design/slfe_parser.sv */
// Frame parser: sync hunt, length capture, size check and pass-through.
// Depends on slfe_pkg; feeds slfe_outq with up to eight words per input word.
`timescale 1ns / 1ps
`default_nettype none

module slfe_parser (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [slfe_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  wire                           i_accept,
    input  wire  [7:0]                    i_byte,
    input  wire                           i_down,
    output slfe_pkg::t_push               o_push
);

    slfe_pkg::t_phase              r_phase, n_phase;
    logic [2:0]                    r_run, n_run;
    logic [2:0]                    r_idx, n_idx;
    logic [31:0]                   r_len, n_len;
    logic [slfe_pkg::LIMIT_W-1:0]  r_left, n_left;
    logic [slfe_pkg::LIMIT_W-1:0]  r_limit;
    logic [32:0]                   total;

    always_comb begin
        n_phase = r_phase;
        n_run   = r_run;
        n_idx   = r_idx;
        n_len   = r_len;
        n_left  = r_left;
        o_push  = '0;
        total   = {1'b0, r_len} + slfe_pkg::FRAME_EXTRA;
        if (i_accept) begin
            if (i_down) begin
                n_phase = slfe_pkg::PH_HUNT;
                n_run   = '0;
                n_idx   = '0;
                n_len   = '0;
                n_left  = '0;
                o_push.cnt = 4'd1;
                o_push.ent[0].link_lost = 1'b1;
            end else begin
                unique case (r_phase)
                    slfe_pkg::PH_LEN: begin
                        n_len = {r_len[23:0], i_byte};
                        n_idx = r_idx + 3'd1;
                        total = {1'b0, n_len} + slfe_pkg::FRAME_EXTRA;
                        if (n_idx >= slfe_pkg::LEN_BYTES) begin
                            if (total >= {16'd0, r_limit}) begin
                                n_phase = slfe_pkg::PH_HUNT;
                                n_run   = '0;
                                n_idx   = '0;
                                n_len   = '0;
                                n_left  = '0;
                            end else begin
                                o_push.cnt = slfe_pkg::HEADER_LEN;
                                for (int k = 0; k < 4; k++) begin
                                    o_push.ent[k].data = slfe_pkg::SYNC_BYTE;
                                end
                                o_push.ent[0].frame_start = 1'b1;
                                o_push.ent[4].data = n_len[31:24];
                                o_push.ent[5].data = n_len[23:16];
                                o_push.ent[6].data = n_len[15:8];
                                o_push.ent[7].data = n_len[7:0];
                                // Bytes after the header: payload plus trailer.
                                n_left  = n_len[slfe_pkg::LIMIT_W-1:0] + 17'd1;
                                n_phase = slfe_pkg::PH_PASS;
                                n_run   = '0;
                                n_idx   = '0;
                            end
                        end
                    end
                    slfe_pkg::PH_PASS: begin
                        n_left = r_left - 17'd1;
                        o_push.cnt = 4'd1;
                        o_push.ent[0].data      = i_byte;
                        o_push.ent[0].frame_end = (n_left == '0);
                        if (n_left == '0) begin
                            n_phase = slfe_pkg::PH_HUNT;
                            n_run   = '0;
                            n_idx   = '0;
                            n_len   = '0;
                        end
                    end
                    default: begin
                        n_phase = slfe_pkg::PH_HUNT;
                        if (i_byte == slfe_pkg::SYNC_BYTE) begin
                            n_run = r_run + 3'd1;
                            if (n_run >= slfe_pkg::SYNC_LEN) begin
                                n_phase = slfe_pkg::PH_LEN;
                                n_run   = '0;
                                n_idx   = '0;
                                n_len   = '0;
                            end
                        end else begin
                            n_run = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= slfe_pkg::PH_HUNT;
            r_run   <= '0;
            r_idx   <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_limit <= slfe_pkg::LIMIT_RESET;
        end else begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_left  <= n_left;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

/* design/slfe_outq.sv */
// Output queue: takes zero, one or eight result words per cycle, drains one when i_pop_ready is high.
// Depends on slfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slfe_outq (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire slfe_pkg::t_push i_push,
    input  wire                i_pop_ready,
    output logic               o_valid,
    output slfe_pkg::t_res     o_res,
    output logic               o_room
);

    slfe_pkg::t_res             mem [slfe_pkg::Q_DEPTH];
    logic [slfe_pkg::Q_AW-1:0]  r_wptr, r_rptr;
    logic [slfe_pkg::Q_AW:0]    r_count;
    logic                       pop;

    assign o_valid = (r_count != '0);
    assign o_res   = mem[r_rptr];
    assign pop     = o_valid & i_pop_ready;
    // Room for a full header burst whatever the drain side does.
    assign o_room  = (r_count <= slfe_pkg::Q_ROOM_MAX);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < slfe_pkg::Q_DEPTH; i++) begin
            if ((slfe_pkg::Q_AW'(i) - r_wptr) < i_push.cnt) begin
                mem[i] <= i_push.ent[3'(slfe_pkg::Q_AW'(i) - r_wptr)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + i_push.cnt;
            r_rptr  <= r_rptr + {{(slfe_pkg::Q_AW-1){1'b0}}, pop};
            r_count <= r_count + {1'b0, i_push.cnt}
                     - {{slfe_pkg::Q_AW{1'b0}}, pop};
        end
    end

endmodule

`default_nettype wire

/* design/sync_length_frame_extractor.sv */
// Top level of the sync-length frame extractor.
// Depends on slfe_pkg, slfe_parser and slfe_outq.
//
// Usage:
//   The slave stream carries one received byte per word (tdata) and a
//   link-down flag (tuser). The block hunts for four 0x02 sync bytes, reads
//   a 32-bit big-endian length and delivers frames of length + 9 bytes on
//   the master stream: header, payload and trailer, with frame_start in
//   tuser[0], frame_end on tlast and link loss in tuser[1]. Frames whose
//   total reaches frame_limit (i_cfg_we / i_cfg_wdata) are dropped silently.
//   A link-down word clears the parser and yields one word with link_lost.
//   One input word is accepted per cycle while s_axis_tready is high; the
//   eight header words of a frame are written at once into a 16-word output
//   queue, and s_axis_tready drops only while that queue holds more than
//   eight words, so a stalled receiver back-pressures the input once the
//   queue holds more than eight words.
//   Reset (synchronous, active low) empties the queue, returns the parser to
//   hunting and sets frame_limit to 4096.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_extractor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [16:0] i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire         s_axis_tuser,   // [0] link_down
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [0] frame_start, [1] link_lost
);

    slfe_pkg::t_push push;
    slfe_pkg::t_res  res;
    logic            room;

    assign s_axis_tready = room;

    slfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (s_axis_tvalid & room),
        .i_byte      (s_axis_tdata),
        .i_down      (s_axis_tuser),
        .o_push      (push)
    );

    slfe_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_res       (res),
        .o_room      (room)
    );

    assign m_axis_tdata = res.data;
    assign m_axis_tlast = res.frame_end;
    assign m_axis_tuser = {res.link_lost, res.frame_start};

endmodule

`default_nettype wire
